// ===== sv/dtoi_pkg.sv =====
// Shared types, constants and codes for the decimal text to int64 parser.
`default_nettype none

package dtoi_pkg;

  // Longest text that is counted; the character position saturates here.
  localparam int unsigned MAX_TEXT_LEN = 4096;
  localparam int unsigned POS_W        = $clog2(MAX_TEXT_LEN + 1);

  // Configuration port geometry.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Field widths.
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned PROD_W   = VALUE_W + 4;
  localparam int unsigned OUT_W    = 80;

  // Result width modes.
  localparam logic [MODE_W-1:0] MODE_S64 = 2'd0;
  localparam logic [MODE_W-1:0] MODE_S32 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_U32 = 2'd2;

  // Parse status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd3;

  // Character codes of interest.
  localparam logic [CHAR_W-1:0] CH_BEL   = 8'h07;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  // Range limits on the magnitude.
  localparam logic [VALUE_W-1:0] LIM_POS64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] LIM_NEG64 = 64'h8000_0000_0000_0000;
  localparam logic [VALUE_W-1:0] LIM_POS32 = 64'h0000_0000_7FFF_FFFF;
  localparam logic [VALUE_W-1:0] LIM_NEG32 = 64'h0000_0000_8000_0000;
  localparam logic [VALUE_W-1:0] LIM_U32   = 64'h0000_0000_FFFF_FFFF;

  // Parse phase, one-hot.
  typedef enum logic [2:0] {
    PH_PREFIX  = 3'b001,
    PH_DIGITS  = 3'b010,
    PH_STOPPED = 3'b100
  } phase_t;

  // One input request as held in the input register.
  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              has_char;
    logic              last_char;
  } item_t;

  // One result request.
  typedef struct packed {
    logic [POS_W-1:0]    stop_index;
    logic [STATUS_W-1:0] parse_status;
    logic [VALUE_W-1:0]  parsed_value;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/dtoi_cfg.sv =====
// APB-style configuration register holding the result width mode.
`default_nettype none

module dtoi_cfg
  import dtoi_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output logic      [MODE_W-1:0]     mode
);

  logic [MODE_W-1:0] mode_r;
  logic [MODE_W-1:0] mode_nxt;
  logic              sel_mode;

  // Every address with the top address bit clear selects the mode register.
  assign sel_mode = (paddr[CFG_ADDR_W-1] == 1'b0);
  assign pready   = 1'b1;

  // Register write on the access cycle.
  always_comb begin
    mode_nxt = mode_r;
    if (psel && penable && pwrite && pready && sel_mode) begin
      mode_nxt = pwdata[MODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_S64;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  // Read back.
  assign prdata = sel_mode ? {{(CFG_DATA_W-MODE_W){1'b0}}, mode_r} : '0;
  assign mode   = mode_r;

endmodule

`default_nettype wire

// ===== sv/dtoi_in_stage.sv =====
// Input register stage that holds one accepted character request.
`default_nettype none

module dtoi_in_stage
  import dtoi_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  input  wire logic  advance,
  output logic       item_valid,
  output item_t      item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  // The register frees up whenever its request moves on.
  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// ===== sv/dtoi_parse.sv =====
// Parser state and the combinational update for one character.
`default_nettype none

module dtoi_parse
  import dtoi_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire item_t             item,
  input  wire logic              advance,
  input  wire logic [MODE_W-1:0] mode,
  output result_t                result
);

  phase_t              phase_r,  phase_nxt;
  logic                neg_r,    neg_nxt;
  logic [VALUE_W-1:0]  acc_r,    acc_nxt;
  logic [POS_W-1:0]    pos_r,    pos_nxt;
  logic [POS_W-1:0]    stop_r,   stop_nxt;
  logic [STATUS_W-1:0] fail_r,   fail_nxt;

  logic                is_digit;
  logic                is_skip;
  logic [3:0]          digit;
  logic [VALUE_W-1:0]  limit;
  logic [PROD_W-1:0]   prod;
  logic                ovf;
  phase_t              ph_mid;
  logic [STATUS_W-1:0] status;
  logic                in_range;

  // Character classes.
  assign is_digit = (item.char_code >= CH_ZERO) && (item.char_code <= CH_NINE);
  assign is_skip  = (item.char_code inside {CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_VT,
                                            CH_FF, CH_BEL, CH_PLUS});
  assign digit    = item.char_code[3:0];

  // Times ten plus digit as shift-add; overflow when it passes the signed limit.
  // A digit never changes the sign, so the held sign selects the limit.
  assign limit = neg_r ? LIM_NEG64 : LIM_POS64;
  assign prod  = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {{(PROD_W-4){1'b0}}, digit};
  assign ovf   = prod > {4'b0000, limit};

  // Next state for one character.
  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    pos_nxt   = pos_r;
    stop_nxt  = stop_r;
    fail_nxt  = fail_r;
    ph_mid    = phase_r;
    if (item.has_char) begin
      // Prefix handling: blanks, BEL and plus skipped, minus flips the sign.
      case (phase_r)
        PH_PREFIX: begin
          if (is_digit) begin
            ph_mid = PH_DIGITS;
          end else if (is_skip) begin
            ph_mid = PH_PREFIX;
          end else if (item.char_code == CH_MINUS) begin
            neg_nxt = !neg_r;
          end else begin
            fail_nxt = ST_BAD;
            ph_mid   = PH_STOPPED;
          end
        end
        PH_DIGITS:  ph_mid = PH_DIGITS;
        PH_STOPPED: ph_mid = PH_STOPPED;
        default:    ph_mid = PH_STOPPED;
      endcase
      phase_nxt = ph_mid;
      // Digit accumulation until the first non-digit.
      if (ph_mid == PH_DIGITS) begin
        if (is_digit) begin
          if (ovf) begin
            fail_nxt  = ST_OVERFLOW;
            phase_nxt = PH_STOPPED;
          end else begin
            acc_nxt = prod[VALUE_W-1:0];
          end
        end else begin
          stop_nxt  = pos_r;
          fail_nxt  = ST_OK;
          phase_nxt = PH_STOPPED;
        end
      end
      if (pos_r != POS_W'(MAX_TEXT_LEN)) begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  // Result for an end-of-text request, from the updated state.
  always_comb begin
    case (phase_nxt)
      PH_PREFIX:  status = ST_BAD;
      PH_DIGITS:  status = ST_OK;
      PH_STOPPED: status = fail_nxt;
      default:    status = ST_BAD;
    endcase
    case (mode)
      MODE_S32: in_range = neg_nxt ? (acc_nxt <= LIM_NEG32) : (acc_nxt <= LIM_POS32);
      MODE_U32: in_range = (acc_nxt == '0) || (!neg_nxt && (acc_nxt <= LIM_U32));
      default:  in_range = 1'b1;
    endcase
    result.parsed_value = '0;
    result.stop_index   = '0;
    result.parse_status = status;
    if (status == ST_OK) begin
      if (!in_range) begin
        result.parse_status = ST_RANGE;
      end else begin
        result.parsed_value = neg_nxt ? (VALUE_W'(0) - acc_nxt) : acc_nxt;
        result.stop_index   = (phase_nxt == PH_DIGITS) ? pos_nxt : stop_nxt;
      end
    end
  end

  // State registers; an end-of-text request returns everything to reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PREFIX;
      neg_r   <= 1'b0;
      acc_r   <= '0;
      pos_r   <= '0;
      stop_r  <= '0;
      fail_r  <= ST_OK;
    end else if (advance) begin
      if (item.last_char) begin
        phase_r <= PH_PREFIX;
        neg_r   <= 1'b0;
        acc_r   <= '0;
        pos_r   <= '0;
        stop_r  <= '0;
        fail_r  <= ST_OK;
      end else begin
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        acc_r   <= acc_nxt;
        pos_r   <= pos_nxt;
        stop_r  <= stop_nxt;
        fail_r  <= fail_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/dtoi_out_stage.sv =====
// Result register that holds one finished result until it is taken.
`default_nettype none

module dtoi_out_stage
  import dtoi_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  wire result_t result,
  output logic         can_take,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_data
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign can_take = !valid_r || out_ready;

  // A new result replaces one that leaves in the same cycle.
  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = res_r;

endmodule

`default_nettype wire

// ===== sv/decimal_text_to_int64.sv =====
// Streaming decimal text to signed 64-bit integer parser, top level.
//
// The input stream carries one ASCII character per request: in_tdata is the
// character, in_tuser says whether a character is present and in_tlast marks
// the end of the text. A request with in_tlast set yields exactly one result
// on the output stream; all other requests yield none.
// Each request passes an input register and then updates the parse state (the
// times-ten accumulate and its overflow compare set the cycle). An end-of-text
// request writes the result register, so its result is valid once the request
// has moved from the input register into the result register. One request is
// taken every cycle unless an end-of-text request waits on a full result
// register; the result register lets new requests in while a result waits.
// If the receiver stalls, a waiting result holds and the next end-of-text
// request is held back in the input register; characters before it keep flowing.
// Reset clears the parse state, drops any held request or result and sets the
// width mode to signed 64-bit. Write the mode over the APB-style port only
// while no text is in flight.
`default_nettype none

module decimal_text_to_int64
  import dtoi_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input stream.
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [CHAR_W-1:0]     in_tdata,   // [7:0] char_code
  input  wire logic                  in_tuser,   // [0] has_char
  input  wire logic                  in_tlast,   // last_char
  // Result stream.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_W-1:0]      out_tdata,  // [63:0] parsed_value,
                                                 // [65:64] parse_status,
                                                 // [78:66] stop_index, [79] zero
  // Configuration port.
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  item_t             in_item;
  item_t             item;
  logic              item_valid;
  logic              advance;
  logic              can_take;
  logic [MODE_W-1:0] mode;
  result_t           result;
  result_t           held_result;

  assign in_item.char_code = in_tdata;
  assign in_item.has_char  = in_tuser;
  assign in_item.last_char = in_tlast;

  // A held request moves on unless it needs the result register and that is full.
  assign advance = item_valid && (!item.last_char || can_take);

  dtoi_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .mode    (mode)
  );

  dtoi_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  dtoi_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (item),
    .advance (advance),
    .mode    (mode),
    .result  (result)
  );

  dtoi_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && item.last_char),
    .result    (result),
    .can_take  (can_take),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (held_result)
  );

  // Pack the result fields from the lowest bit up.
  assign out_tdata = {{(OUT_W-VALUE_W-STATUS_W-POS_W){1'b0}}, held_result.stop_index,
                      held_result.parse_status, held_result.parsed_value};

endmodule

`default_nettype wire
